@@ design/itoa_pkg.sv @@
// shared constants, types and helpers for the signed integer to decimal text core
package itoa_pkg;

  localparam int unsigned VALUE_W   = 32;
  localparam int unsigned NUM_DIGITS = 10;
  localparam int unsigned BCD_W     = 4 * NUM_DIGITS;
  localparam int unsigned BIT_CNT_W = $clog2(VALUE_W);
  localparam int unsigned DIG_CNT_W = $clog2(NUM_DIGITS);

  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;

  localparam logic [BIT_CNT_W-1:0] LAST_BIT   = BIT_CNT_W'(VALUE_W - 1);
  localparam logic [DIG_CNT_W-1:0] TOP_DIGIT  = DIG_CNT_W'(NUM_DIGITS - 1);

  typedef logic [BCD_W-1:0] bcd_t;

  // status of the bit-serial converter as seen by the top level
  typedef struct packed {
    logic active;
    logic done;
  } dabble_status_t;

  // add three to every decimal digit of five or more, ahead of the shift
  function automatic bcd_t bcd_adjust(input bcd_t bcd);
    bcd_t res;
    logic [3:0] d;
    res = bcd;
    for (int i = 0; i < NUM_DIGITS; i++) begin
      d = bcd[4*i +: 4];
      res[4*i +: 4] = (d >= 4'd5) ? d + 4'd3 : d;
    end
    return res;
  endfunction

endpackage

@@ design/itoa_dabble.sv @@
// bit-serial binary to packed decimal converter, one magnitude bit per cycle
module itoa_dabble (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          load,
  input  logic [itoa_pkg::VALUE_W-1:0]  mag_in,
  output itoa_pkg::bcd_t                bcd,
  output itoa_pkg::dabble_status_t      status
);
  import itoa_pkg::*;

  logic [VALUE_W-1:0]   mag;
  logic [BIT_CNT_W-1:0] cnt;
  logic                 active;
  logic                 done;
  bcd_t                 bcd_next;

  always_comb begin
    bcd_next = bcd_adjust(bcd);
    bcd_next = {bcd_next[BCD_W-2:0], mag[VALUE_W-1]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      done   <= 1'b0;
    end else begin
      done <= active && (cnt == LAST_BIT);
      if (load) begin
        active <= 1'b1;
      end else if (active && (cnt == LAST_BIT)) begin
        active <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      mag <= mag_in;
      bcd <= '0;
      cnt <= '0;
    end else if (active) begin
      mag <= {mag[VALUE_W-2:0], 1'b0};
      bcd <= bcd_next;
      cnt <= cnt + 1'b1;
    end
  end

  assign status.active = active;
  assign status.done   = done;

endmodule

@@ design/itoa_emit.sv @@
// character emitter: optional sign, then digits with leading zeros dropped
module itoa_emit (
  input  logic           clk,
  input  logic           rst,
  input  logic           load,
  input  logic           negative,
  input  itoa_pkg::bcd_t bcd,
  output logic           active,
  output logic           strobe,
  output logic [7:0]     character,
  output logic           last
);
  import itoa_pkg::*;

  bcd_t                 digits;
  logic [DIG_CNT_W-1:0] idx;
  logic                 sign_pending;
  logic                 started;
  logic [3:0]           top;
  logic                 show;

  assign top  = digits[BCD_W-1 -: 4];
  assign show = started || (top != 4'd0) || (idx == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      strobe <= 1'b0;
    end else begin
      strobe <= 1'b0;
      if (load) begin
        active <= 1'b1;
      end else if (active) begin
        if (sign_pending) begin
          strobe <= 1'b1;
        end else begin
          strobe <= show;
          if (idx == '0) begin
            active <= 1'b0;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      digits       <= bcd;
      idx          <= TOP_DIGIT;
      sign_pending <= negative;
      started      <= 1'b0;
    end else if (active) begin
      if (sign_pending) begin
        character    <= CHAR_MINUS;
        last         <= 1'b0;
        sign_pending <= 1'b0;
      end else begin
        character <= CHAR_ZERO + {4'd0, top};
        last      <= (idx == '0);
        digits    <= {digits[BCD_W-5:0], 4'd0};
        idx       <= idx - 1'b1;
        started   <= show;
      end
    end
  end

endmodule

@@ design/signed_int_to_decimal_ascii_core.sv @@
// top level: signed 32-bit integer to decimal ascii text, one character per strobe
//
//   channel   ports                    direction  transaction
//   command   start, busy, value       in         start high while busy low
//   result    strobe, character, last  out        every cycle strobe is high
//
// one transaction loads the value, shifts its magnitude through the bit-serial
// binary to decimal converter, hands the digits over, then emits a minus sign
// if the value is negative, then the ten digit positions, before busy falls.
// leading zero digits still take their turn but raise no strobe.
// results leave at one per cycle at most and cannot be held off by the receiver.
// rst is synchronous and active high; it clears the sequencing flags only.
module signed_int_to_decimal_ascii_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic signed [31:0] value,
  output logic        strobe,
  output logic [7:0]  character,
  output logic        last
);
  import itoa_pkg::*;

  logic                  accept;
  logic                  negative;
  logic [VALUE_W-1:0]    mag;
  bcd_t                  bcd;
  dabble_status_t        dab_status;
  logic                  emit_active;

  // new transaction only when every stage has drained
  assign accept = start && !busy;
  assign busy   = dab_status.active || dab_status.done || emit_active;

  // magnitude as unsigned, so the most negative value stays exact
  assign mag = value[VALUE_W-1] ? (VALUE_W'(0) - VALUE_W'(value)) : VALUE_W'(value);

  // sign is held for the emitter until the digits are ready
  always_ff @(posedge clk) begin
    if (accept) begin
      negative <= value[VALUE_W-1];
    end
  end

  itoa_dabble u_dabble (
    .clk    (clk),
    .rst    (rst),
    .load   (accept),
    .mag_in (mag),
    .bcd    (bcd),
    .status (dab_status)
  );

  itoa_emit u_emit (
    .clk       (clk),
    .rst       (rst),
    .load      (dab_status.done),
    .negative  (negative),
    .bcd       (bcd),
    .active    (emit_active),
    .strobe    (strobe),
    .character (character),
    .last      (last)
  );

endmodule

@@ test/decimal_text_checker.sv @@
// checker: predicts the decimal text of each accepted value and compares every strobed character
module decimal_text_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic               busy,
  input  logic signed [31:0] value,
  input  logic               strobe,
  input  logic [7:0]         character,
  input  logic               last,
  output int                 fail_count,
  output int                 chars_pending
);
  import itoa_pkg::*;

  typedef struct packed {
    logic [7:0] ch;
    logic       fin;
  } text_char_t;

  text_char_t expected_text[$];

  initial begin
    fail_count    = 0;
    chars_pending = 0;
  end

  // sign first, then digits most significant first, last flag on the final digit
  task automatic queue_decimal_text(input logic [31:0] raw);
    logic       neg;
    logic [31:0] mag;
    logic [3:0] digs [NUM_DIGITS];
    int         n;
    neg = raw[31];
    mag = neg ? (32'd0 - raw) : raw;
    n   = 0;
    do begin
      digs[n] = 4'(mag % 32'd10);
      n++;
      mag = mag / 32'd10;
    end while (mag != 32'd0 && n < NUM_DIGITS);
    if (neg) expected_text.push_back('{ch: CHAR_MINUS, fin: 1'b0});
    for (int k = n - 1; k >= 0; k--) begin
      expected_text.push_back('{ch: CHAR_ZERO + 8'(digs[k]), fin: (k == 0)});
    end
  endtask

  always @(posedge clk) begin
    text_char_t want;
    if (!rst) begin
      if (strobe !== 1'b0) begin
        if (expected_text.size() == 0) begin
          if (fail_count < 10)
            $display("unexpected character %h last %b at %0t", character, last, $realtime);
          fail_count++;
        end else begin
          want = expected_text.pop_front();
          if (strobe !== 1'b1 || character !== want.ch || last !== want.fin) begin
            if (fail_count < 10)
              $display("mismatch at %0t: expected char %h last %b, got char %h last %b",
                       $realtime, want.ch, want.fin, character, last);
            fail_count++;
          end
        end
      end
      if (start === 1'b1 && busy === 1'b0) queue_decimal_text(value);
    end
    chars_pending = expected_text.size();
  end

endmodule

@@ test/tb.sv @@
// testbench top: drives signed values into the decimal text core and gives the verdict
module tb;
  import itoa_pkg::*;

  logic               clk;
  logic               rst;
  logic               start;
  logic signed [31:0] value;
  wire                busy;
  wire                strobe;
  wire  [7:0]         character;
  wire                last;
  int                 fail_count;
  int                 chars_pending;

  // extremes, digit-count boundaries and the most negative value
  logic signed [31:0] corner_values [18] = '{
    32'sd0, 32'sd1, -32'sd1, 32'sd9, 32'sd10, -32'sd9, -32'sd10, 32'sd99, 32'sd100,
    -32'sd100, 32'sh7fff_ffff, -32'sh7fff_ffff, 32'sh8000_0000, 32'sd999999999,
    32'sd1000000000, -32'sd1000000000, 32'sd1234567890, -32'sd1234567890
  };

  signed_int_to_decimal_ascii_core uut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .value     (value),
    .strobe    (strobe),
    .character (character),
    .last      (last)
  );

  decimal_text_checker chk (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .value         (value),
    .strobe        (strobe),
    .character     (character),
    .last          (last),
    .fail_count    (fail_count),
    .chars_pending (chars_pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // hard stop well beyond the slowest correct run
  initial begin
    #2_000_000;
    $display("Regression FAIL");
    $finish;
  end

  // hold one transaction on the command channel until it is taken; returns at a falling edge
  task automatic send_value(input logic [31:0] v);
    start = 1'b1;
    value = v;
    do @(posedge clk); while (busy !== 1'b0);
    @(negedge clk);
  endtask

  // sender idles for a burst; value is scrambled so an ignored command is also exercised
  task automatic idle_sender(input int cycles);
    start = 1'b0;
    value = $urandom;
    repeat (cycles) @(negedge clk);
  endtask

  // sender holds off until every expected character has arrived
  task automatic drain_text;
    start = 1'b0;
    while (chars_pending != 0) @(negedge clk);
  endtask

  // mix of digit lengths, signs, boundaries and fully random bit patterns
  function automatic logic [31:0] pick_value();
    int                kind;
    int                n;
    logic              neg;
    longint unsigned   lo;
    longint unsigned   hi;
    longint unsigned   r;
    longint unsigned   mag;
    kind = $urandom_range(0, 9);
    if (kind < 2) return $urandom;
    if (kind == 2) begin
      case ($urandom_range(0, 5))
        0: return 32'h0000_0000;
        1: return 32'h8000_0000;
        2: return 32'h7fff_ffff;
        3: return 32'hffff_ffff;
        4: return 32'h8000_0001;
        default: return 32'h0000_0001;
      endcase
    end
    n   = $urandom_range(1, 10);
    neg = 1'($urandom_range(0, 1));
    lo  = 1;
    repeat (n - 1) lo = lo * 10;
    hi  = lo * 10 - 1;
    if (hi > 64'd2147483647) hi = neg ? 64'd2147483648 : 64'd2147483647;
    if (n == 1) lo = 0;
    r   = {$urandom, $urandom};
    mag = lo + r % (hi - lo + 1);
    return neg ? (32'd0 - mag[31:0]) : mag[31:0];
  endfunction

  initial begin
    rst   = 1'b1;
    start = 1'b0;
    value = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed part, mostly back to back, one idle burst in the middle
    foreach (corner_values[i]) begin
      if (i == 9) idle_sender(3);
      send_value(corner_values[i]);
    end
    drain_text();

    // random part; idling stops for the last stretch
    for (int i = 0; i < 360; i++) begin
      if (i < 300 && $urandom_range(0, 3) == 0) idle_sender($urandom_range(1, 17));
      if (i == 150) drain_text();
      send_value(pick_value());
    end

    drain_text();
    repeat (60) @(negedge clk);
    if (fail_count == 0 && chars_pending == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
